### rtl/itf_pkg.sv
// ---------------------------------------------------------------------------
// itf_pkg
// Shared widths, flag bit positions, ASCII codes and the digit-to-character
// mapping of the integer-to-text formatter.
// ---------------------------------------------------------------------------
package itf_pkg;

  localparam int VALUE_W       = 64;
  localparam int RADIX_W       = 6;
  localparam int CNT_W         = 7;
  localparam int FLAGS_W       = 7;
  localparam int CHAR_W        = 8;
  localparam int DIGIT_W       = 6;
  localparam int DIG_DEPTH     = 64;
  localparam int DIG_AW        = 6;
  localparam int ND_W          = 7;
  localparam int TOT_W         = 9;
  localparam int MAX_CHARS_DEF = 64;

  localparam int RADIX_MIN = 2;
  localparam int RADIX_MAX = 36;
  localparam int DIGIT_X   = 33;

  localparam int FL_ZEROPAD = 0;
  localparam int FL_SIGNED  = 1;
  localparam int FL_PLUS    = 2;
  localparam int FL_SPACE   = 3;
  localparam int FL_LEFT    = 4;
  localparam int FL_PREFIX  = 5;
  localparam int FL_UPPER   = 6;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_UA    = 8'h41;
  localparam char_t CH_LA    = 8'h61;

  function automatic char_t digit_char(input digit_t d, input logic upper);
    char_t base_ch;
    base_ch = upper ? CH_UA : CH_LA;
    if (d < digit_t'(10)) begin
      return CH_ZERO + {2'b00, d};
    end
    return base_ch + {2'b00, d} - 8'd10;
  endfunction

endpackage

### rtl/integer_to_text_formatter_core.sv
// ---------------------------------------------------------------------------
// integer_to_text_formatter_core
// printf-style integer conversion, one ASCII character per strobe.
// Sequence: a setup state, then one division per digit in the shared serial
// divider, then the sizing and planning states, then one character per cycle
// except at each field boundary, where none is sent; a selected character
// passes through the p_ stage and the output register. One item at a time.
// Sync reset clears the sequencer and the strobe; the sink cannot stall.
// ---------------------------------------------------------------------------
module integer_to_text_formatter_core #(
  parameter int MAX_CHARS = itf_pkg::MAX_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [itf_pkg::VALUE_W-1:0]   value,
  input  logic [itf_pkg::RADIX_W-1:0]   radix,
  input  logic [itf_pkg::CNT_W-1:0]     min_width,
  input  logic [itf_pkg::CNT_W-1:0]     min_digits,
  input  logic [itf_pkg::FLAGS_W-1:0]   flags,
  output logic                          strobe,
  output itf_pkg::char_t                char_out,
  output logic                          last,
  output logic                          truncated
);
  import itf_pkg::*;

  localparam int PW = $clog2(MAX_CHARS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SIZE  = 3'd3;
  localparam logic [2:0] S_PLAN  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam logic [2:0] G_LEAD  = 3'd0;
  localparam logic [2:0] G_SIGN  = 3'd1;
  localparam logic [2:0] G_PREF  = 3'd2;
  localparam logic [2:0] G_ZPAD  = 3'd3;
  localparam logic [2:0] G_PZERO = 3'd4;
  localparam logic [2:0] G_DIGIT = 3'd5;
  localparam logic [2:0] G_TRAIL = 3'd6;

  logic [2:0]           state;
  logic [VALUE_W-1:0]   mag;
  logic [RADIX_W-1:0]   base;
  logic [FLAGS_W-1:0]   fl;
  logic [CNT_W-1:0]     fw;
  logic [CNT_W-1:0]     mind;
  char_t                sign_ch;
  logic                 sign_len;
  logic [1:0]           pref_len;
  logic [ND_W-1:0]      nd;
  logic [CNT_W-1:0]     prec;
  logic [CNT_W-1:0]     padcnt;
  logic [PW-1:0]        n_emit;
  logic                 trunc_r;
  logic [PW-1:0]        pos;
  logic [2:0]           seg;
  logic [CNT_W-1:0]     seg_left;
  logic [DIG_AW-1:0]    dptr;

  logic                 p_valid;
  logic                 p_dig;
  char_t                p_char;
  logic                 p_last;
  logic                 p_trunc;
  logic                 p_upper;

  logic                 good_base;
  logic                 neg;
  logic [VALUE_W-1:0]   mag_abs;
  logic                 mag_zero;
  logic [1:0]           pref_len_c;
  logic [CNT_W-1:0]     prec_c;
  logic [TOT_W-1:0]     w_c;
  logic [TOT_W-1:0]     tot_c;
  logic [CNT_W-1:0]     lead_len;
  logic [CNT_W-1:0]     next_len;
  logic                 emit_now;
  logic                 emit_last;
  char_t                fix_ch;

  logic                 div_go;
  logic                 div_done;
  logic [VALUE_W-1:0]   div_quot;
  digit_t               div_rem;
  logic [VALUE_W-1:0]   dividend;

  logic                 ram_we;
  logic [DIG_AW-1:0]    ram_waddr;
  digit_t               ram_wdata;
  digit_t               ram_rdata;

  assign busy = (state != S_IDLE);

  assign good_base = (base >= RADIX_W'(RADIX_MIN)) && (base <= RADIX_W'(RADIX_MAX));
  assign neg       = fl[FL_SIGNED] & mag[VALUE_W-1];
  assign mag_abs   = neg ? (~mag + VALUE_W'(1)) : mag;
  assign mag_zero  = (mag_abs == '0);

  always_comb begin
    pref_len_c = 2'd0;
    if (fl[FL_PREFIX]) begin
      if (base == RADIX_W'(16)) begin
        pref_len_c = 2'd2;
      end else if (base == RADIX_W'(8)) begin
        pref_len_c = 2'd1;
      end
    end
  end

  assign prec_c   = (nd > mind) ? nd : mind;
  assign w_c      = TOT_W'(fw) - TOT_W'(sign_len) - TOT_W'(pref_len) - TOT_W'(prec_c);
  assign tot_c    = TOT_W'(padcnt) + TOT_W'(sign_len) + TOT_W'(pref_len) + TOT_W'(prec);
  assign lead_len = (!fl[FL_ZEROPAD] && !fl[FL_LEFT]) ? padcnt : '0;

  always_comb begin
    case (seg + 3'd1)
      G_SIGN:  next_len = CNT_W'(sign_len);
      G_PREF:  next_len = CNT_W'(pref_len);
      G_ZPAD:  next_len = fl[FL_ZEROPAD] ? padcnt : '0;
      G_PZERO: next_len = prec - nd;
      G_DIGIT: next_len = nd;
      G_TRAIL: next_len = fl[FL_LEFT] ? padcnt : '0;
      default: next_len = '0;
    endcase
  end

  always_comb begin
    case (seg)
      G_SIGN:  fix_ch = sign_ch;
      G_PREF:  fix_ch = (pref_len == 2'd2 && seg_left == CNT_W'(1))
                        ? digit_char(DIGIT_W'(DIGIT_X), fl[FL_UPPER]) : CH_ZERO;
      G_ZPAD:  fix_ch = CH_ZERO;
      G_PZERO: fix_ch = CH_ZERO;
      default: fix_ch = CH_SPACE;
    endcase
  end

  assign emit_now  = (state == S_EMIT) && (seg_left != '0);
  assign emit_last = (pos == n_emit - PW'(1));

  assign div_go   = ((state == S_SETUP) && good_base && !mag_zero) ||
                    ((state == S_DIV) && div_done && (div_quot != '0));
  assign dividend = (state == S_DIV) ? div_quot : mag_abs;

  assign ram_we    = ((state == S_SETUP) && good_base && mag_zero) ||
                     ((state == S_DIV) && div_done);
  assign ram_waddr = (state == S_DIV) ? nd[DIG_AW-1:0] : '0;
  assign ram_wdata = (state == S_DIV) ? div_rem : '0;

  itf_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (dividend),
    .divisor   (base),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  itf_digit_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (dptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      p_valid <= 1'b0;
      strobe  <= 1'b0;
      nd      <= '0;
    end else begin
      p_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            mag   <= value;
            base  <= radix;
            fw    <= min_width;
            mind  <= min_digits;
            fl    <= flags & ~(FLAGS_W'(flags[FL_LEFT]) << FL_ZEROPAD);
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          sign_len <= neg | (fl[FL_SIGNED] & (fl[FL_PLUS] | fl[FL_SPACE]));
          sign_ch  <= neg ? CH_MINUS : (fl[FL_PLUS] ? CH_PLUS : CH_SPACE);
          pref_len <= pref_len_c;
          if (!good_base) begin
            state <= S_IDLE;
          end else if (mag_zero) begin
            nd    <= ND_W'(1);
            state <= S_SIZE;
          end else begin
            nd    <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            nd <= nd + ND_W'(1);
            if (div_quot == '0) begin
              state <= S_SIZE;
            end
          end
        end
        S_SIZE: begin
          prec   <= prec_c;
          padcnt <= (!w_c[TOT_W-1] && w_c != '0) ? w_c[CNT_W-1:0] : '0;
          state  <= S_PLAN;
        end
        S_PLAN: begin
          n_emit   <= (tot_c > TOT_W'(MAX_CHARS)) ? PW'(MAX_CHARS) : tot_c[PW-1:0];
          trunc_r  <= (tot_c > TOT_W'(MAX_CHARS));
          seg      <= G_LEAD;
          seg_left <= lead_len;
          pos      <= '0;
          dptr     <= DIG_AW'(nd - ND_W'(1));
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (seg_left == '0) begin
            seg      <= seg + 3'd1;
            seg_left <= next_len;
          end else begin
            p_valid  <= 1'b1;
            p_dig    <= (seg == G_DIGIT);
            p_char   <= fix_ch;
            p_last   <= emit_last;
            p_trunc  <= emit_last & trunc_r;
            p_upper  <= fl[FL_UPPER];
            seg_left <= seg_left - CNT_W'(1);
            pos      <= pos + PW'(1);
            if (seg == G_DIGIT) begin
              dptr <= dptr - DIG_AW'(1);
            end
            if (emit_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      strobe    <= p_valid;
      char_out  <= p_dig ? digit_char(ram_rdata, p_upper) : p_char;
      last      <= p_valid & p_last;
      truncated <= p_valid & p_trunc;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after transfer");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("character strobed right after the last one");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    nd <= ND_W'(DIG_DEPTH))
    else $error("digit count overflow");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    emit_now |-> pos < n_emit)
    else $error("character past the output limit");

  a_div_base: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> base >= RADIX_W'(RADIX_MIN) && base <= RADIX_W'(RADIX_MAX))
    else $error("division with a bad base");

endmodule

### rtl/itf_divider.sv
// ---------------------------------------------------------------------------
// itf_divider
// Restoring bit-serial divider: 64-bit dividend by a 6-bit radix, one
// quotient bit per cycle, done pulses after the last step.
// ---------------------------------------------------------------------------
module itf_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [itf_pkg::VALUE_W-1:0]   dividend,
  input  logic [itf_pkg::RADIX_W-1:0]   divisor,
  output logic                          done,
  output logic [itf_pkg::VALUE_W-1:0]   quotient,
  output itf_pkg::digit_t               remainder
);
  import itf_pkg::*;

  localparam int STEP_W = $clog2(VALUE_W + 1);

  logic [VALUE_W-1:0] q;
  digit_t             r;
  logic [RADIX_W-1:0] dsr;
  logic [STEP_W-1:0]  cnt;
  logic               active;
  logic [DIGIT_W:0]   trial;
  logic               ge;

  assign trial = {r, q[VALUE_W-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        q      <= dividend;
        r      <= '0;
        dsr    <= divisor;
        cnt    <= STEP_W'(VALUE_W);
        active <= 1'b1;
      end else if (active) begin
        q   <= {q[VALUE_W-2:0], ge};
        r   <= ge ? DIGIT_W'(trial - {1'b0, dsr}) : trial[DIGIT_W-1:0];
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q;
  assign remainder = r;

endmodule

### rtl/itf_digit_ram.sv
// ---------------------------------------------------------------------------
// itf_digit_ram
// Digit store, one write port and one registered read port.
// ---------------------------------------------------------------------------
module itf_digit_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [itf_pkg::DIG_AW-1:0] waddr,
  input  itf_pkg::digit_t            wdata,
  input  logic [itf_pkg::DIG_AW-1:0] raddr,
  output itf_pkg::digit_t            rdata
);
  import itf_pkg::*;

  digit_t mem [DIG_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
